### rtl/mepr_pkg.sv
// Shared types and constants for the multi-encoder pulse reporter.
package mepr_pkg;

  // Number of scanned encoders (1 to 6, as the pin word holds six); the report layout is fixed.
  localparam int unsigned ENC_COUNT = 6;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned PIN_W     = 12;
  localparam int unsigned PAD_W     = 16;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned LOW_W     = 8;
  localparam int unsigned HIGH_W    = 6;

  localparam logic [HOLD_W-1:0] HOLD_LIMIT_RST = 16'h0300;
  localparam logic [IDX_W-1:0]  FAST_ENC       = 3'd3;
  localparam logic [1:0]        DETENT_LAST    = 2'd3;

  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] DIR_CW  = 2'b10;
  localparam logic [1:0] DIR_CCW = 2'b01;

  // Controller to datapath.
  typedef struct packed {
    logic             load;
    logic             step;
    logic             finish;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_tick;
    logic out_free;
  } sts_t;

endpackage

### rtl/mepr_ctrl.sv
// Sequencer for the multi-encoder pulse reporter: accept, per-encoder steps, finish.
module mepr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mepr_pkg::sts_t sts,
  output mepr_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                     state_r;
  logic [mepr_pkg::IDX_W-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            idx_r   <= '0;
            state_r <= (sts.is_tick) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx_r == mepr_pkg::IDX_W'(mepr_pkg::ENC_COUNT - 1)) begin
            state_r <= ST_FINISH;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_FINISH: begin
          if (sts.out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign cmd.load   = (state_r == ST_IDLE) && in_valid;
  assign cmd.step   = (state_r == ST_SCAN);
  assign cmd.finish = (state_r == ST_FINISH) && sts.out_free;
  assign cmd.idx    = idx_r;

endmodule

### rtl/mepr_datapath.sv
// Datapath for the multi-encoder pulse reporter: pin compare, detent, hold timer, output.
module mepr_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mepr_pkg::cmd_t                cmd,
  output mepr_pkg::sts_t                sts,
  input  logic                          in_kind,
  input  logic [mepr_pkg::PIN_W-1:0]    in_encoder_pins,
  input  logic                          cfg_wr_en,
  input  logic [mepr_pkg::HOLD_W-1:0]   cfg_wr_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mepr_pkg::LOW_W-1:0]    out_report_low,
  output logic [mepr_pkg::HIGH_W-1:0]   out_report_high,
  output logic                          out_scan_changed
);

  logic                          kind_r;
  logic [mepr_pkg::PIN_W-1:0]    pins_r;
  logic [mepr_pkg::PIN_W-1:0]    prev_r;
  logic [1:0]                    detent_r;
  logic                          pending_r;
  logic [mepr_pkg::HOLD_W-1:0]   hold_cnt_r;
  logic                          expired_r;
  logic [mepr_pkg::HOLD_W-1:0]   hold_limit_r;
  logic [mepr_pkg::LOW_W-1:0]    held_low_r;
  logic [mepr_pkg::HIGH_W-1:0]   held_high_r;
  logic [mepr_pkg::PAD_W-1:0]    norm_r;
  logic [1:0]                    fast3_r;
  logic                          out_valid_r;
  logic [mepr_pkg::LOW_W-1:0]    out_low_r;
  logic [mepr_pkg::HIGH_W-1:0]   out_high_r;
  logic                          out_chg_r;

  logic [mepr_pkg::PAD_W-1:0]    new_pad;
  logic [mepr_pkg::PAD_W-1:0]    old_pad;
  logic [1:0]                    new_pair;
  logic [1:0]                    old_pair;
  logic [1:0]                    dir;
  logic [mepr_pkg::HOLD_W-1:0]   hold_next;
  logic [mepr_pkg::LOW_W-1:0]    build_low;
  logic [mepr_pkg::HIGH_W-1:0]   build_high;

  // Pins past the input word read as zero.
  assign new_pad  = {{(mepr_pkg::PAD_W - mepr_pkg::PIN_W){1'b0}}, pins_r}
                    >> {cmd.idx, 1'b0};
  assign old_pad  = {{(mepr_pkg::PAD_W - mepr_pkg::PIN_W){1'b0}}, prev_r}
                    >> {cmd.idx, 1'b0};
  assign new_pair = new_pad[1:0];
  assign old_pair = old_pad[1:0];
  // New phase a against old phase b.
  assign dir      = (new_pair[1] ^ old_pair[0]) ? mepr_pkg::DIR_CCW : mepr_pkg::DIR_CW;

  assign hold_next  = hold_cnt_r + 1'b1;
  assign build_low  = norm_r[7:0];
  assign build_high = {norm_r[11:8], fast3_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r       <= '0;
      detent_r     <= '0;
      pending_r    <= 1'b1;
      hold_cnt_r   <= '0;
      expired_r    <= 1'b0;
      hold_limit_r <= mepr_pkg::HOLD_LIMIT_RST;
      held_low_r   <= '0;
      held_high_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        hold_limit_r <= cfg_wr_data;
      end

      if (cmd.step && (old_pair != new_pair)) begin
        pending_r <= 1'b1;
        if (detent_r != mepr_pkg::DETENT_LAST) begin
          detent_r <= detent_r + 1'b1;
        end else begin
          detent_r <= '0;
        end
      end

      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (kind_r == mepr_pkg::KIND_TICK) begin
          if (hold_next == hold_limit_r) begin
            expired_r  <= 1'b1;
            hold_cnt_r <= '0;
          end else begin
            hold_cnt_r <= hold_next;
          end
        end else begin
          prev_r <= pins_r;
          // A rebuild drops any pending expiry.
          if (pending_r) begin
            held_low_r  <= build_low;
            held_high_r <= build_high;
            pending_r   <= 1'b0;
            expired_r   <= 1'b0;
            hold_cnt_r  <= '0;
          end else if (expired_r) begin
            held_low_r  <= '0;
            held_high_r <= '0;
            detent_r    <= '0;
            expired_r   <= 1'b0;
          end
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      pins_r  <= in_encoder_pins;
      norm_r  <= '0;
      fast3_r <= '0;
    end else if (cmd.step && (old_pair != new_pair)) begin
      if (detent_r != mepr_pkg::DETENT_LAST) begin
        norm_r[{cmd.idx, 1'b0} +: 2] <= dir;
      end else if (cmd.idx == mepr_pkg::FAST_ENC) begin
        fast3_r <= dir;
      end
    end

    if (cmd.finish) begin
      if (kind_r == mepr_pkg::KIND_TICK) begin
        out_low_r  <= held_low_r;
        out_high_r <= held_high_r;
        out_chg_r  <= 1'b0;
      end else if (pending_r) begin
        out_low_r  <= build_low;
        out_high_r <= build_high;
        out_chg_r  <= 1'b1;
      end else if (expired_r) begin
        out_low_r  <= '0;
        out_high_r <= '0;
        out_chg_r  <= 1'b0;
      end else begin
        out_low_r  <= held_low_r;
        out_high_r <= held_high_r;
        out_chg_r  <= 1'b0;
      end
    end
  end

  assign sts.is_tick  = (in_kind == mepr_pkg::KIND_TICK);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_report_low   = out_low_r;
  assign out_report_high  = out_high_r;
  assign out_scan_changed = out_chg_r;

endmodule

### rtl/multi_encoder_pulse_reporter_unit.sv
// Top level of the multi-encoder pulse reporter: controller plus datapath.
//
// Scans six two-phase rotary encoders and reports turn direction in 14
// bits (report_low and report_high). An item is either a pin scan or one
// prescaled timer tick. A scan holds the input side through the accept
// step that latches the pins, a step per encoder through the shared phase
// compare and detent counter, and a finish step that rebuilds or clears
// the reports; the result is registered from the finish step. A tick
// holds the input side through accept and finish only.
// The input side accepts one item at a time; the result sits in an output
// register, so the next item is accepted while the previous result still
// waits to be taken. The finish step of that next item waits for as long
// as the earlier result is stalled, so output stalls lengthen the time
// that an item holds the input side.
// Every fourth direction step (shared detent count) is
// a fast step; only encoder 3 reports fast steps, in report_high[1:0].
// After hold_limit ticks with no change the next scan clears the reports
// and the detent counter. A limit of zero means 65536 ticks. The first
// scan after reset always reports. cfg_wr_en writes hold_limit (reset 768)
// and must only be used while the block is idle.
module multi_encoder_pulse_reporter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [mepr_pkg::PIN_W-1:0]    in_encoder_pins,
  input  logic                          cfg_wr_en,
  input  logic [mepr_pkg::HOLD_W-1:0]   cfg_wr_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mepr_pkg::LOW_W-1:0]    out_report_low,
  output logic [mepr_pkg::HIGH_W-1:0]   out_report_high,
  output logic                          out_scan_changed
);

  mepr_pkg::cmd_t cmd;
  mepr_pkg::sts_t sts;

  // Sequencer: owns the handshake on the input side and the encoder index.
  mepr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: per-encoder compare, detent, hold timer, output register.
  mepr_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_kind),
    .in_encoder_pins  (in_encoder_pins),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_report_low   (out_report_low),
    .out_report_high  (out_report_high),
    .out_scan_changed (out_scan_changed)
  );

`ifndef NO_ASSERTIONS
  // An accepted item keeps the input side busy next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // A new result only appears from the finish step, while busy.
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without finished item");

  // Encoder step and finish never overlap.
  a_step_finish_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step && cmd.finish))
    else $error("step and finish at once");
`endif

endmodule
